### rtl/mqttp_pkg.sv
// Shared types and constants for the MQTT fixed-header parser.
// Used by the front, the event queue, the back and the top level; no dependencies.
`default_nettype none

package mqttp_pkg;

  // Parser phase of the front part.
  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2,
    PH_HALT = 2'd3
  } phase_e;

  // Result kind as seen on the kind port.
  typedef enum logic [2:0] {
    KIND_REPLY      = 3'd0,
    KIND_PUBLISH    = 3'd1,
    KIND_DISCONNECT = 3'd2,
    KIND_BADTYPE    = 3'd3,
    KIND_BADLEN     = 3'd4
  } kind_e;

  // Class of a packet-end event handed from the front to the back.
  typedef enum logic [2:0] {
    EV_CONNACK    = 3'd0,
    EV_PINGRESP   = 3'd1,
    EV_SUBACK     = 3'd2,
    EV_PUBLISH    = 3'd3,
    EV_DISCONNECT = 3'd4,
    EV_BADTYPE    = 3'd5,
    EV_BADLEN     = 3'd6
  } ev_e;

  localparam int unsigned LenW  = 28;
  localparam int unsigned PlenW = 29;

  // Packet type bytes, matched on the whole byte.
  localparam logic [7:0] TYPE_CONNECT    = 8'h10;
  localparam logic [7:0] TYPE_PUBLISH    = 8'h30;
  localparam logic [7:0] TYPE_SUBSCRIBE  = 8'h82;
  localparam logic [7:0] TYPE_PINGREQ    = 8'hc0;
  localparam logic [7:0] TYPE_DISCONNECT = 8'he0;

  localparam logic [7:0] CONNACK_BYTES [4] = '{8'h20, 8'h02, 8'h00, 8'h00};
  localparam logic [7:0] PINGRESP_BYTES [2] = '{8'hd0, 8'h00};
  localparam logic [7:0] SUBACK_HEAD0 = 8'h90;
  localparam logic [7:0] SUBACK_HEAD1 = 8'h03;
  localparam logic [7:0] SUBACK_OK    = 8'h00;

  // One packet-end event.
  typedef struct packed {
    ev_e              cls;
    logic [7:0]       type_byte;
    logic [PlenW-1:0] plen;
    logic [15:0]      word;
  } ev_t;

endpackage

`default_nettype wire

### rtl/mqttp_front.sv
// Front part: takes one received byte per beat, tracks the fixed header and body,
// and produces one packet-end event into the event queue. Depends on mqttp_pkg.
`default_nettype none

module mqttp_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [7:0]     rx_byte_i,
  output logic                ev_valid_o,
  output mqttp_pkg::ev_t      ev_o
);
  import mqttp_pkg::*;

  phase_e          phase_q, phase_d;
  logic [7:0]      type_q, type_d;
  logic [LenW-1:0] accum_q, accum_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [LenW-1:0] left_q, left_d;
  logic [2:0]      bidx_q, bidx_d;
  logic [15:0]     word_q, word_d;

  logic [LenW-1:0] group;
  logic [1:0]      k;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      type_q  <= '0;
      accum_q <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
      bidx_q  <= '0;
      word_q  <= '0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      accum_q <= accum_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      bidx_q  <= bidx_d;
      word_q  <= word_d;
    end
  end

  // Seven value bits of a length byte placed at their group position.
  always_comb begin
    k = cnt_q[1:0];
    case (k)
      2'd0:    group = {21'b0, rx_byte_i[6:0]};
      2'd1:    group = {14'b0, rx_byte_i[6:0], 7'b0};
      2'd2:    group = {7'b0, rx_byte_i[6:0], 14'b0};
      default: group = {rx_byte_i[6:0], 21'b0};
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    type_d     = type_q;
    accum_d    = accum_q;
    cnt_d      = cnt_q;
    left_d     = left_q;
    bidx_d     = bidx_q;
    word_d     = word_q;
    ev_valid_o = 1'b0;
    ev_o.cls   = EV_BADLEN;
    ev_o.type_byte = type_q;
    ev_o.plen  = '0;
    ev_o.word  = '0;
    if (accept_i) begin
      unique case (phase_q)
        PH_TYPE: begin
          type_d  = rx_byte_i;
          accum_d = '0;
          cnt_d   = '0;
          left_d  = '0;
          bidx_d  = '0;
          word_d  = '0;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          accum_d = accum_q | group;
          cnt_d   = {1'b0, k} + 3'd1;
          if (rx_byte_i[7]) begin
            if (k == 2'd3) begin
              ev_valid_o = 1'b1;
              ev_o.cls   = EV_BADLEN;
              phase_d    = PH_HALT;
            end
          end else begin
            left_d = accum_d;
            if (accum_d == '0) begin
              ev_valid_o = 1'b1;
            end else begin
              phase_d = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (bidx_q == 3'd0) begin
            word_d = {rx_byte_i, 8'h00};
          end else if (bidx_q == 3'd1) begin
            word_d = {word_q[15:8], rx_byte_i};
          end
          if (bidx_q != 3'd7) begin
            bidx_d = bidx_q + 3'd1;
          end
          if (left_q != '0) begin
            left_d = left_q - LenW'(1);
          end
          if (left_d == '0) begin
            ev_valid_o = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // Packet end: classify the type byte and go back to wait for the next one, or halt on an unknown type.
      if (ev_valid_o && phase_d != PH_HALT) begin
        ev_o.plen = PlenW'(1) + PlenW'(cnt_d) + PlenW'(accum_d);
        phase_d   = PH_TYPE;
        unique case (type_q)
          TYPE_CONNECT:    ev_o.cls = EV_CONNACK;
          TYPE_PINGREQ:    ev_o.cls = EV_PINGRESP;
          TYPE_SUBSCRIBE:  ev_o.cls = EV_SUBACK;
          TYPE_PUBLISH:    ev_o.cls = EV_PUBLISH;
          TYPE_DISCONNECT: ev_o.cls = EV_DISCONNECT;
          default: begin
            ev_o.cls = EV_BADTYPE;
            phase_d  = PH_HALT;
          end
        endcase
        ev_o.word = word_d;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/mqttp_queue.sv
// Two-entry event queue between the front and the back.
// Depends on mqttp_pkg for the event type.
`default_nettype none

module mqttp_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  mqttp_pkg::ev_t      data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output mqttp_pkg::ev_t      data_o
);
  import mqttp_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  ev_t        e0_q, e1_q;
  logic       do_pop;
  logic [1:0] wr_slot;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = e0_q;
  assign do_pop  = pop_i && valid_o;
  assign wr_slot = cnt_q - {1'b0, do_pop};
  assign cnt_d   = cnt_q + {1'b0, push_i} - {1'b0, do_pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A push into the head slot takes priority over the shift from the second slot.
  always_ff @(posedge clk_i) begin
    if (push_i && wr_slot == 2'd0) begin
      e0_q <= data_i;
    end else if (do_pop) begin
      e0_q <= e1_q;
    end
    if (push_i && wr_slot == 2'd1) begin
      e1_q <= data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/mqttp_back.sv
// Back part: holds one event and expands it into its result beats, one per pop.
// Depends on mqttp_pkg for event classes, result kinds and reply tables.
`default_nettype none

module mqttp_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_valid_i,
  input  mqttp_pkg::ev_t                    q_data_i,
  output logic                              q_pop_o,
  output logic                              empty_o,
  input  wire logic                         pop_i,
  output logic [2:0]                        kind_o,
  output logic [7:0]                        data_byte_o,
  output logic                              last_o,
  output logic [mqttp_pkg::PlenW-1:0]       packet_length_o,
  output logic [15:0]                       topic_length_o
);
  import mqttp_pkg::*;

  ev_t        cur_q;
  logic       cur_valid_q;
  logic [2:0] idx_q;
  logic [2:0] last_idx;
  logic       load;
  kind_e      kind;

  always_comb begin
    unique case (cur_q.cls)
      EV_CONNACK:  last_idx = 3'd3;
      EV_PINGRESP: last_idx = 3'd1;
      EV_SUBACK:   last_idx = 3'd4;
      default:     last_idx = 3'd0;
    endcase
  end

  assign last_o  = (idx_q == last_idx);
  assign empty_o = !cur_valid_q;
  assign load    = !cur_valid_q || (pop_i && last_o);
  assign q_pop_o = load && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      cur_valid_q <= q_valid_i;
      idx_q       <= '0;
    end else if (pop_i) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
  end

  always_comb begin
    kind            = KIND_REPLY;
    data_byte_o     = cur_q.type_byte;
    packet_length_o = cur_q.plen;
    topic_length_o  = '0;
    unique case (cur_q.cls)
      EV_CONNACK:  data_byte_o = CONNACK_BYTES[idx_q[1:0]];
      EV_PINGRESP: data_byte_o = PINGRESP_BYTES[idx_q[0]];
      EV_SUBACK: begin
        unique case (idx_q)
          3'd0:    data_byte_o = SUBACK_HEAD0;
          3'd1:    data_byte_o = SUBACK_HEAD1;
          3'd2:    data_byte_o = cur_q.word[15:8];
          3'd3:    data_byte_o = cur_q.word[7:0];
          default: data_byte_o = SUBACK_OK;
        endcase
      end
      EV_PUBLISH: begin
        kind           = KIND_PUBLISH;
        topic_length_o = cur_q.word;
      end
      EV_DISCONNECT: kind = KIND_DISCONNECT;
      EV_BADTYPE:    kind = KIND_BADTYPE;
      default: begin
        kind            = KIND_BADLEN;
        packet_length_o = '0;
      end
    endcase
  end

  assign kind_o = kind;

endmodule

`default_nettype wire

### rtl/mqtt_packet_header_parser.sv
// MQTT fixed-header parser: one received byte per beat in, reply and notice beats out.
// Each packet-end event is registered in the queue, then in the back, before it shows.
// One byte per cycle unless full; each packet end emits one to five beats, one per pop.
// Input stalls (full high) only when the two-entry event queue holds two events.
// Reset (rst_ni low, asynchronous) clears the parser, the queue and the output stage.
// Depends on mqttp_pkg, mqttp_front, mqttp_queue and mqttp_back.
`default_nettype none

module mqtt_packet_header_parser (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [7:0]                   rx_byte_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [2:0]                        kind_o,
  output logic [7:0]                        data_byte_o,
  output logic                              last_o,
  output logic [mqttp_pkg::PlenW-1:0]       packet_length_o,
  output logic [15:0]                       topic_length_o
);
  import mqttp_pkg::*;

  // The front takes a beat whenever the queue has room. It never needs more
  // than one queue slot per byte, so a full queue is the only reason to stall.
  logic accept;
  logic ev_valid;
  ev_t  ev;
  logic q_valid;
  ev_t  q_data;
  logic q_pop;

  assign accept = push && !full;

  mqttp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .ev_valid_o (ev_valid),
    .ev_o       (ev)
  );

  // The queue decouples byte parsing from reply expansion, so a multi-byte
  // reply does not hold up the bytes of the next packet.
  mqttp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ev_valid),
    .data_i  (ev),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  // The back holds one event at a time and walks through its reply bytes.
  mqttp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (q_data),
    .q_pop_o         (q_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .last_o          (last_o),
    .packet_length_o (packet_length_o),
    .topic_length_o  (topic_length_o)
  );

  // A bad length result carries no lengths and ends its byte's results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_BADLEN) |->
      (packet_length_o == '0 && topic_length_o == '0 && last_o))
    else $error("bad length beat carries lengths or is not last");

  // Only a publish notice carries a topic length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_PUBLISH) |-> (topic_length_o == '0))
    else $error("topic length on a non-publish beat");

  // Every complete packet has a type byte and at least one length byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_BADLEN) |-> (packet_length_o >= PlenW'(2)))
    else $error("packet length below the fixed header size");

  // Notices and errors are single beats.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (kind_o == KIND_PUBLISH || kind_o == KIND_DISCONNECT ||
                kind_o == KIND_BADTYPE)) |-> last_o)
    else $error("notice or error beat not marked last");

endmodule

`default_nettype wire
